>>> design/jsu_pkg.sv
`timescale 1ns / 1ps
package jsu_pkg;

	typedef enum logic [2:0] {
		M_IDLE,
		M_BODY,
		M_ESC,
		M_HEX,
		M_SURR_BS,
		M_SURR_U,
		M_HEX2,
		M_UTF8
	} mode_t;

	typedef enum logic [3:0] {
		ST_DATA      = 4'd0,
		ST_END       = 4'd1,
		ST_BAD_START = 4'd2,
		ST_BAD_ESC   = 4'd3,
		ST_BAD_HEX   = 4'd4,
		ST_BAD_PAIR  = 4'd5,
		ST_BAD_LEAD  = 4'd6,
		ST_BAD_CONT  = 4'd7,
		ST_EOF       = 4'd8
	} status_t;

	// one input byte's worth of results
	typedef struct packed {
		logic [2:0]      cnt;
		status_t         stat;
		logic [3:0][7:0] data;
	} grp_t;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_U      = 8'h75;

	localparam logic [5:0]  SURR_HI_TAG = 6'b110110;
	localparam logic [5:0]  SURR_LO_TAG = 6'b110111;
	localparam logic [10:0] SUPP_BASE   = 11'h040;

	// {valid, value}
	function automatic logic [4:0] hex_digit(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) r = {1'b1, b[3:0]};
		else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
			r = {1'b1, b[3:0] + 4'd9};
		return r;
	endfunction

	function automatic logic [2:0] lead_len(input logic [7:0] b);
		logic [2:0] r;
		r = 3'd0;
		if (b[7] == 1'b0) r = 3'd1;
		else if (b[7:5] == 3'b110) r = 3'd2;
		else if (b[7:4] == 4'b1110) r = 3'd3;
		else if (b[7:3] == 5'b11110) r = 3'd4;
		return r;
	endfunction

	// {valid, byte} for single-character escapes
	function automatic logic [8:0] esc_map(input logic [7:0] b);
		logic [8:0] r;
		r = 9'd0;
		case (b)
			CH_QUOTE:  r = {1'b1, 8'h22};
			CH_BSLASH: r = {1'b1, 8'h5C};
			CH_SLASH:  r = {1'b1, 8'h2F};
			CH_B:      r = {1'b1, 8'h08};
			CH_F:      r = {1'b1, 8'h0C};
			CH_N:      r = {1'b1, 8'h0A};
			CH_R:      r = {1'b1, 8'h0D};
			CH_T:      r = {1'b1, 8'h09};
			default:   r = 9'd0;
		endcase
		return r;
	endfunction

	function automatic grp_t encode_cp(input logic [20:0] cp);
		grp_t g;
		g = '0;
		g.stat = ST_DATA;
		if (cp < 21'h80) begin
			g.cnt = 3'd1;
			g.data[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			g.cnt = 3'd2;
			g.data[0] = {3'b110, cp[10:6]};
			g.data[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			g.cnt = 3'd3;
			g.data[0] = {4'b1110, cp[15:12]};
			g.data[1] = {2'b10, cp[11:6]};
			g.data[2] = {2'b10, cp[5:0]};
		end else begin
			g.cnt = 3'd4;
			g.data[0] = {5'b11110, cp[20:18]};
			g.data[1] = {2'b10, cp[17:12]};
			g.data[2] = {2'b10, cp[11:6]};
			g.data[3] = {2'b10, cp[5:0]};
		end
		return g;
	endfunction

endpackage

>>> design/json_string_unescape.sv
`timescale 1ns / 1ps
// an accepted input item's results are written into the queue, then loaded into the output register before they leave
// throughput: one input item per cycle while the queue is not full, one result item per cycle while m_tready is high
// an input item with n results gives n output bytes in order; a 4-group queue absorbs bursts
// reset: arst_n clears the parser to idle (waiting for an opening quote) and empties the queue
module json_string_unescape import jsu_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tlast,   // end_of_input
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic [3:0] m_tuser,   // status
	output logic       m_tlast    // last_of_run
);

	logic push;
	logic pop;
	logic full;
	logic empty;
	grp_t wr_grp;
	grp_t rd_grp;

	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_byte  (s_tdata),
		.in_eof   (s_tlast),
		.push     (push),
		.push_grp (wr_grp),
		.q_full   (full)
	);

	jsu_queue #(.DEPTH(DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_grp (wr_grp),
		.full   (full),
		.pop    (pop),
		.rd_grp (rd_grp),
		.empty  (empty)
	);

	jsu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.rd_grp     (rd_grp),
		.empty      (empty),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_status (m_tuser),
		.out_last   (m_tlast)
	);

endmodule

>>> design/jsu_front.sv
`timescale 1ns / 1ps
module jsu_front import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_eof,
	output logic       push,
	output grp_t       push_grp,
	input  logic       q_full
);

	mode_t           mode_q;
	logic [15:0]     accum_q;
	logic [1:0]      hcnt_q;
	logic [9:0]      high_q;
	logic [3:0][7:0] seq_q;
	logic [2:0]      need_q;
	logic [2:0]      have_q;

	mode_t           mode_n;
	logic [15:0]     accum_n;
	logic [1:0]      hcnt_n;
	logic [9:0]      high_n;
	logic [3:0][7:0] seq_n;
	logic [2:0]      need_n;
	logic [2:0]      have_n;
	grp_t            g;
	logic            fin;
	logic            accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (g.cnt != 3'd0);
	assign push_grp = g;

	always_comb begin
		mode_t       m_eff;
		logic [4:0]  hv;
		logic [8:0]  em;
		logic [2:0]  len;
		logic [15:0] acc;
		mode_n  = mode_q;
		accum_n = accum_q;
		hcnt_n  = hcnt_q;
		high_n  = high_q;
		seq_n   = seq_q;
		need_n  = need_q;
		have_n  = have_q;
		g       = '0;
		g.stat  = ST_DATA;
		fin     = 1'b0;
		hv      = hex_digit(in_byte);
		em      = esc_map(in_byte);
		len     = lead_len(in_byte);
		acc     = {accum_q[11:0], hv[3:0]};

		// a pending surrogate gives way to ordinary body or escape decoding
		m_eff = mode_q;
		if (mode_q == M_SURR_BS && in_byte != CH_BSLASH) m_eff = M_BODY;
		if (mode_q == M_SURR_U && in_byte != CH_U) m_eff = M_ESC;

		unique case (m_eff)
			M_IDLE: begin
				if (in_byte == CH_QUOTE) begin
					mode_n = M_BODY;
				end else if (in_byte != CH_SPACE && in_byte != CH_LF &&
				             in_byte != CH_CR && in_byte != CH_TAB) begin
					g.cnt = 3'd1; g.stat = ST_BAD_START; fin = 1'b1; mode_n = M_IDLE;
				end
			end
			M_BODY: begin
				if (in_byte == CH_QUOTE) begin
					g.cnt = 3'd1; g.stat = ST_END; fin = 1'b1; mode_n = M_IDLE;
				end else if (in_byte == CH_BSLASH) begin
					mode_n = M_ESC;
				end else if (len == 3'd0) begin
					g.cnt = 3'd1; g.stat = ST_BAD_LEAD; fin = 1'b1; mode_n = M_IDLE;
				end else if (len == 3'd1) begin
					g.cnt = 3'd1; g.data[0] = in_byte; mode_n = M_BODY;
				end else begin
					seq_n[0] = in_byte;
					need_n   = len;
					have_n   = 3'd1;
					mode_n   = M_UTF8;
				end
			end
			M_ESC: begin
				if (in_byte == CH_U) begin
					hcnt_n = 2'd0;
					mode_n = M_HEX;
				end else if (em[8]) begin
					g.cnt = 3'd1; g.data[0] = em[7:0]; mode_n = M_BODY;
				end else begin
					g.cnt = 3'd1; g.stat = ST_BAD_ESC; fin = 1'b1; mode_n = M_IDLE;
				end
			end
			M_SURR_BS: begin
				mode_n = M_SURR_U;
			end
			M_SURR_U: begin
				hcnt_n = 2'd0;
				mode_n = M_HEX2;
			end
			M_HEX, M_HEX2: begin
				if (!hv[4]) begin
					g.cnt = 3'd1; g.stat = ST_BAD_HEX; fin = 1'b1; mode_n = M_IDLE;
				end else begin
					accum_n = acc;
					if (hcnt_q != 2'd3) begin
						hcnt_n = hcnt_q + 2'd1;
					end else begin
						hcnt_n = 2'd0;
						if (m_eff == M_HEX2) begin
							if (acc[15:10] == SURR_LO_TAG) begin
								g = encode_cp({11'(high_q) + SUPP_BASE, acc[9:0]});
								mode_n = M_BODY;
							end else begin
								g.cnt = 3'd1; g.stat = ST_BAD_PAIR; fin = 1'b1;
								mode_n = M_IDLE;
							end
						end else if (acc[15:10] == SURR_HI_TAG) begin
							high_n = acc[9:0];
							mode_n = M_SURR_BS;
						end else if (acc[15:10] == SURR_LO_TAG) begin
							g.cnt = 3'd1; g.stat = ST_BAD_PAIR; fin = 1'b1; mode_n = M_IDLE;
						end else begin
							g = encode_cp({5'd0, acc});
							mode_n = M_BODY;
						end
					end
				end
			end
			M_UTF8: begin
				if (in_byte[7:6] != 2'b10) begin
					g.cnt = 3'd1; g.stat = ST_BAD_CONT; fin = 1'b1; mode_n = M_IDLE;
				end else begin
					seq_n[have_q[1:0]] = in_byte;
					have_n = have_q + 3'd1;
					if (have_n >= need_q) begin
						g.cnt  = need_q;
						g.data = seq_n;
						have_n = 3'd0;
						need_n = 3'd0;
						mode_n = M_BODY;
					end
				end
			end
			default: mode_n = M_IDLE;
		endcase

		if (in_eof && !fin) begin
			g = '0;
			g.cnt = 3'd1;
			g.stat = (mode_q == M_IDLE && mode_n == M_IDLE) ? ST_BAD_START : ST_EOF;
		end
		if (in_eof) mode_n = M_IDLE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			hcnt_q <= 2'd0;
			need_q <= 3'd0;
			have_q <= 3'd0;
		end else if (accept) begin
			mode_q <= mode_n;
			hcnt_q <= hcnt_n;
			need_q <= need_n;
			have_q <= have_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			accum_q <= accum_n;
			high_q  <= high_n;
			seq_q   <= seq_n;
		end
	end

endmodule

>>> design/jsu_queue.sv
`timescale 1ns / 1ps
module jsu_queue import jsu_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  grp_t wr_grp,
	output logic full,
	input  logic pop,
	output grp_t rd_grp,
	output logic empty
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	grp_t          mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_grp = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			if (pop) rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_grp;
	end

endmodule

>>> design/jsu_back.sv
`timescale 1ns / 1ps
module jsu_back import jsu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  grp_t       rd_grp,
	input  logic       empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [3:0] out_status,
	output logic       out_last
);

	grp_t       cur_q;
	logic       cur_vld_q;
	logic [1:0] idx_q;
	logic       done;

	assign out_valid  = cur_vld_q;
	assign out_byte   = cur_q.data[idx_q];
	assign out_status = cur_q.stat;
	assign out_last   = ({1'b0, idx_q} == (cur_q.cnt - 3'd1));
	assign done       = !cur_vld_q || (out_ready && out_last);
	assign pop        = done && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_vld_q <= 1'b0;
			idx_q     <= 2'd0;
		end else if (pop) begin
			cur_vld_q <= 1'b1;
			idx_q     <= 2'd0;
		end else if (done) begin
			cur_vld_q <= 1'b0;
		end else if (out_ready) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) cur_q <= rd_grp;
	end

endmodule

>>> test/json_string_unescape_test.sv
`timescale 1ns / 1ps
module json_string_unescape_test;
	import jsu_pkg::*;

	typedef struct packed {
		logic [7:0] b;
		status_t    s;
		logic       lst;
	} decoded_t;

	typedef struct packed {
		logic [7:0] b;
		logic       e;
		logic       typed;
		logic [7:0] xb;
		status_t    xs;
	} dir_row_t;

	localparam int DIR_ROWS = 28;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [3:0] m_tuser;
	logic       m_tlast;

	json_string_unescape u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// directed rows: byte, end of input, typed expectation, expected byte, expected status
	dir_row_t dir_tab [DIR_ROWS] = '{
		'{8'hFF,     1'b0, 1'b1, 8'h00, ST_BAD_START},
		'{CH_SPACE,  1'b1, 1'b1, 8'h00, ST_BAD_START},
		'{CH_CR,     1'b0, 1'b0, 8'h00, ST_DATA},
		'{CH_QUOTE,  1'b0, 1'b0, 8'h00, ST_DATA},
		'{8'h00,     1'b0, 1'b1, 8'h00, ST_DATA},
		'{8'hFF,     1'b0, 1'b1, 8'h00, ST_BAD_LEAD},
		'{CH_QUOTE,  1'b0, 1'b0, 8'h00, ST_DATA},
		'{CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_DATA},
		'{8'h71,     1'b0, 1'b1, 8'h00, ST_BAD_ESC},
		'{CH_QUOTE,  1'b0, 1'b0, 8'h00, ST_DATA},
		'{CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_DATA},
		'{CH_U,      1'b0, 1'b0, 8'h00, ST_DATA},
		'{8'h64,     1'b0, 1'b0, 8'h00, ST_DATA},
		'{8'h46,     1'b0, 1'b0, 8'h00, ST_DATA},
		'{8'h66,     1'b0, 1'b0, 8'h00, ST_DATA},
		'{8'h46,     1'b0, 1'b1, 8'h00, ST_BAD_PAIR},
		'{CH_QUOTE,  1'b0, 1'b0, 8'h00, ST_DATA},
		'{CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_DATA},
		'{CH_U,      1'b0, 1'b0, 8'h00, ST_DATA},
		'{8'h44,     1'b0, 1'b0, 8'h00, ST_DATA},
		'{8'h42,     1'b0, 1'b0, 8'h00, ST_DATA},
		'{8'h46,     1'b0, 1'b0, 8'h00, ST_DATA},
		'{8'h46,     1'b0, 1'b0, 8'h00, ST_DATA},
		'{CH_QUOTE,  1'b0, 1'b1, 8'h00, ST_END},
		'{CH_QUOTE,  1'b0, 1'b0, 8'h00, ST_DATA},
		'{CH_BSLASH, 1'b0, 1'b0, 8'h00, ST_DATA},
		'{CH_T,      1'b0, 1'b0, 8'h00, ST_DATA},
		'{8'h61,     1'b1, 1'b1, 8'h00, ST_EOF}
	};

	logic [7:0] esc_chars [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T};

	decoded_t   decoded_q [$];
	logic [8:0] burst [$];
	int         errors = 0;
	int         items_in = 0;
	bit         tx_calm = 1'b0;
	bit         rx_calm = 1'b0;
	int         rx_hold = 0;

	// parser state
	mode_t       pm = M_IDLE;
	logic [15:0] p_acc = '0;
	logic [2:0]  p_ndig = '0;
	logic [9:0]  p_hi = '0;
	logic [7:0]  p_seq [4];
	logic [2:0]  p_need = '0;
	logic [2:0]  p_have = '0;

	// results of the current byte
	logic [7:0] res_b [4];
	status_t    res_s [4];
	int         res_n;
	bit         res_closed;

	function automatic void emit(input logic [7:0] b, input status_t s);
		if (res_n < 4) begin
			res_b[res_n] = b;
			res_s[res_n] = s;
			res_n++;
		end
	endfunction

	function automatic void abort_str(input status_t s);
		emit(8'h00, s);
		res_closed = 1'b1;
		pm = M_IDLE;
	endfunction

	function automatic int hexval(input logic [7:0] b);
		if (b >= 8'h30 && b <= 8'h39) return b - 8'h30;
		if (b >= 8'h61 && b <= 8'h66) return b - 8'h61 + 10;
		if (b >= 8'h41 && b <= 8'h46) return b - 8'h41 + 10;
		return -1;
	endfunction

	function automatic int seq_len(input logic [7:0] b);
		if (!b[7]) return 1;
		if (b[7:5] == 3'b110) return 2;
		if (b[7:4] == 4'b1110) return 3;
		if (b[7:3] == 5'b11110) return 4;
		return 0;
	endfunction

	function automatic void put_cp(input logic [20:0] cp);
		if (cp < 21'h80) begin
			emit(cp[7:0], ST_DATA);
		end else if (cp < 21'h800) begin
			emit(8'hC0 | cp[10:6], ST_DATA);
			emit(8'h80 | cp[5:0], ST_DATA);
		end else if (cp < 21'h10000) begin
			emit(8'hE0 | cp[15:12], ST_DATA);
			emit(8'h80 | cp[11:6], ST_DATA);
			emit(8'h80 | cp[5:0], ST_DATA);
		end else begin
			emit(8'hF0 | cp[20:18], ST_DATA);
			emit(8'h80 | cp[17:12], ST_DATA);
			emit(8'h80 | cp[11:6], ST_DATA);
			emit(8'h80 | cp[5:0], ST_DATA);
		end
	endfunction

	function automatic void body_byte(input logic [7:0] b);
		int n;
		if (b == CH_QUOTE) begin
			emit(8'h00, ST_END);
			res_closed = 1'b1;
			pm = M_IDLE;
		end else if (b == CH_BSLASH) begin
			pm = M_ESC;
		end else begin
			n = seq_len(b);
			if (n == 0) abort_str(ST_BAD_LEAD);
			else if (n == 1) emit(b, ST_DATA);
			else begin
				p_seq[0] = b;
				p_need = 3'(n);
				p_have = 3'd1;
				pm = M_UTF8;
			end
		end
	endfunction

	function automatic void esc_byte(input logic [7:0] b);
		pm = M_BODY;
		case (b)
			CH_QUOTE:  emit(8'h22, ST_DATA);
			CH_BSLASH: emit(8'h5C, ST_DATA);
			CH_SLASH:  emit(8'h2F, ST_DATA);
			CH_B:      emit(8'h08, ST_DATA);
			CH_F:      emit(8'h0C, ST_DATA);
			CH_N:      emit(8'h0A, ST_DATA);
			CH_R:      emit(8'h0D, ST_DATA);
			CH_T:      emit(8'h09, ST_DATA);
			CH_U: begin
				p_acc = '0;
				p_ndig = '0;
				pm = M_HEX;
			end
			default:   abort_str(ST_BAD_ESC);
		endcase
	endfunction

	function automatic void hex_byte(input logic [7:0] b, input bit second);
		int d;
		logic [15:0] v;
		d = hexval(b);
		if (d < 0) begin
			abort_str(ST_BAD_HEX);
			return;
		end
		p_acc = {p_acc[11:0], d[3:0]};
		p_ndig = p_ndig + 3'd1;
		if (p_ndig < 3'd4) return;
		p_ndig = '0;
		v = p_acc;
		if (second) begin
			if (v >= 16'hDC00 && v <= 16'hDFFF) begin
				put_cp(21'h10000 + {p_hi, v[9:0]});
				pm = M_BODY;
			end else begin
				abort_str(ST_BAD_PAIR);
			end
		end else if (v >= 16'hD800 && v <= 16'hDBFF) begin
			p_hi = v[9:0];
			pm = M_SURR_BS;
		end else if (v >= 16'hDC00 && v <= 16'hDFFF) begin
			abort_str(ST_BAD_PAIR);
		end else begin
			put_cp({5'd0, v});
			pm = M_BODY;
		end
	endfunction

	function automatic void cont_byte(input logic [7:0] b);
		if (b[7:6] != 2'b10) begin
			abort_str(ST_BAD_CONT);
			return;
		end
		p_seq[p_have[1:0]] = b;
		p_have = p_have + 3'd1;
		if (p_have >= p_need) begin
			for (int i = 0; i < p_need; i++) emit(p_seq[i], ST_DATA);
			p_have = '0;
			p_need = '0;
			pm = M_BODY;
		end
	endfunction

	function automatic void unescape_step(input logic [7:0] b, input logic e);
		bit was_idle;
		res_n = 0;
		res_closed = 1'b0;
		was_idle = (pm == M_IDLE);
		case (pm)
			M_IDLE: begin
				if (b == CH_QUOTE) pm = M_BODY;
				else if (b != CH_SPACE && b != CH_LF && b != CH_CR && b != CH_TAB)
					abort_str(ST_BAD_START);
			end
			M_BODY: body_byte(b);
			M_ESC:  esc_byte(b);
			M_HEX:  hex_byte(b, 1'b0);
			M_HEX2: hex_byte(b, 1'b1);
			M_SURR_BS: begin
				if (b == CH_BSLASH) pm = M_SURR_U;
				else begin
					pm = M_BODY;
					body_byte(b);
				end
			end
			M_SURR_U: begin
				if (b == CH_U) begin
					p_acc = '0;
					p_ndig = '0;
					pm = M_HEX2;
				end else begin
					esc_byte(b);
				end
			end
			default: cont_byte(b);
		endcase
		// end of input that does not close a string: EOF if one was open, else a bad start
		if (e && !res_closed) begin
			res_n = 0;
			if (was_idle && pm == M_IDLE) emit(8'h00, ST_BAD_START);
			else emit(8'h00, ST_EOF);
		end
		if (e) pm = M_IDLE;
	endfunction

	// stimulus builders
	function automatic void add(input logic [7:0] b);
		burst.push_back({1'b0, b});
	endfunction

	function automatic void add_u(input logic [15:0] v);
		logic [3:0] nib;
		add(CH_BSLASH);
		add(CH_U);
		for (int i = 3; i >= 0; i--) begin
			nib = v[i*4 +: 4];
			if (nib < 4'd10) add(8'h30 + {4'd0, nib});
			else add(($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'd0, nib} - 8'd10);
		end
	endfunction

	function automatic void add_good(input int kind);
		logic [7:0] c;
		logic [15:0] v;
		int r;
		case (kind)
			0: begin
				c = 8'($urandom_range(8'h20, 8'h7E));
				if (c == CH_QUOTE || c == CH_BSLASH) c = 8'h61;
				add(c);
			end
			1: add(8'($urandom_range(0, 8'h1F)));
			2: begin
				add(8'hC0 | 8'($urandom_range(0, 31)));
				add(8'h80 | 8'($urandom_range(0, 63)));
			end
			3: begin
				add(8'hE0 | 8'($urandom_range(0, 15)));
				repeat (2) add(8'h80 | 8'($urandom_range(0, 63)));
			end
			4: begin
				add(8'hF0 | 8'($urandom_range(0, 7)));
				repeat (3) add(8'h80 | 8'($urandom_range(0, 63)));
			end
			5: begin
				add(CH_BSLASH);
				add(esc_chars[$urandom_range(0, 7)]);
			end
			6: begin
				r = $urandom_range(0, 2);
				if (r == 0) v = 16'($urandom_range(0, 16'h7F));
				else if (r == 1) v = 16'($urandom_range(16'h80, 16'h7FF));
				else v = 16'($urandom_range(0, 16'hFFFF));
				if (v[15:11] == 5'b11011) v[15] = 1'b0;
				add_u(v);
			end
			7: begin
				add_u(16'hD800 | 16'($urandom_range(0, 1023)));
				add_u(16'hDC00 | 16'($urandom_range(0, 1023)));
			end
			8: begin
				add_u(16'hD800 | 16'($urandom_range(0, 1023)));
				add_good($urandom_range(0, 4));
			end
			default: begin
				add_u(16'hD800 | 16'($urandom_range(0, 1023)));
				add(CH_BSLASH);
				add(esc_chars[$urandom_range(0, 7)]);
			end
		endcase
	endfunction

	function automatic void add_bad(input int kind);
		logic [7:0] c;
		logic [15:0] v;
		bit ok;
		int n;
		case (kind)
			0: begin
				add(CH_BSLASH);
				do begin
					c = 8'($urandom_range(0, 255));
					ok = (c != CH_U);
					foreach (esc_chars[i]) if (c == esc_chars[i]) ok = 1'b0;
				end while (!ok);
				add(c);
			end
			1: begin
				add(CH_BSLASH);
				add(CH_U);
				repeat ($urandom_range(0, 3)) add(8'h30 + 8'($urandom_range(0, 9)));
				do c = 8'($urandom_range(0, 255)); while (hexval(c) >= 0);
				add(c);
			end
			2: add($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
				: 8'($urandom_range(8'hF8, 8'hFF)));
			3: begin
				n = $urandom_range(2, 4);
				if (n == 2) add(8'hC0 | 8'($urandom_range(0, 31)));
				else if (n == 3) add(8'hE0 | 8'($urandom_range(0, 15)));
				else add(8'hF0 | 8'($urandom_range(0, 7)));
				repeat ($urandom_range(0, n - 2)) add(8'h80 | 8'($urandom_range(0, 63)));
				do c = 8'($urandom_range(0, 255)); while (c[7:6] == 2'b10);
				add(c);
			end
			4: add_u(16'hDC00 | 16'($urandom_range(0, 1023)));
			default: begin
				add_u(16'hD800 | 16'($urandom_range(0, 1023)));
				do v = 16'($urandom_range(0, 16'hFFFF)); while (v[15:10] == SURR_LO_TAG);
				add_u(v);
			end
		endcase
	endfunction

	function automatic void make_string();
		logic [7:0] ws [4] = '{CH_SPACE, CH_LF, CH_CR, CH_TAB};
		logic [7:0] c;
		int r;
		int idx;
		burst.delete();
		repeat ($urandom_range(0, 2)) add(ws[$urandom_range(0, 3)]);
		if ($urandom_range(0, 9) == 0) begin
			do c = 8'($urandom_range(0, 255));
			while (c == CH_QUOTE || c == CH_SPACE || c == CH_LF || c == CH_CR || c == CH_TAB);
			add(c);
		end
		add(CH_QUOTE);
		repeat ($urandom_range(0, 6)) add_good($urandom_range(0, 9));
		r = $urandom_range(0, 99);
		if (r < 70) begin
			add(CH_QUOTE);
			if ($urandom_range(0, 9) == 0) burst[burst.size() - 1][8] = 1'b1;
		end else if (r < 90) begin
			add_bad($urandom_range(0, 5));
		end else begin
			// input ends at a random byte of the burst, possibly before the opening quote
			idx = $urandom_range(0, burst.size() - 1);
			burst[idx][8] = 1'b1;
			while (burst.size() > idx + 1) void'(burst.pop_back());
		end
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 2);
		if (r < 96) return $urandom_range(3, 6);
		return $urandom_range(10, 30);
	endfunction

	task automatic send_item(input logic [7:0] b, input logic e, input logic typed,
			input logic [7:0] xb, input status_t xs);
		int gap;
		decoded_t d;
		gap = tx_calm ? 0 : gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= e;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		unescape_step(b, e);
		if (typed) begin
			d.b = xb;
			d.s = xs;
			d.lst = 1'b1;
			decoded_q.push_back(d);
		end else begin
			for (int k = 0; k < res_n; k++) begin
				d.b = res_b[k];
				d.s = res_s[k];
				d.lst = (k == res_n - 1);
				decoded_q.push_back(d);
			end
		end
		items_in++;
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// output side: checking and back-pressure
	always @(posedge clk) begin
		int r;
		decoded_t d;
		if (arst_n && m_tvalid && m_tready) begin
			if (decoded_q.size() == 0) begin
				$display("%0t: unexpected item byte=%h status=%0d last=%b",
					$time, m_tdata, m_tuser, m_tlast);
				errors++;
			end else begin
				d = decoded_q.pop_front();
				if (m_tdata !== d.b || m_tuser !== d.s || m_tlast !== d.lst) begin
					$display("%0t: expected byte=%h status=%0d last=%b, got byte=%h status=%0d last=%b",
						$time, d.b, d.s, d.lst, m_tdata, m_tuser, m_tlast);
					errors++;
				end
			end
		end
		if ($urandom_range(0, 199) == 0) rx_calm = !rx_calm;
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (rx_calm || r < 60) begin
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b0;
				rx_hold = (r < 90) ? $urandom_range(0, 2) : $urandom_range(5, 25);
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIR_ROWS; i++)
			send_item(dir_tab[i].b, dir_tab[i].e, dir_tab[i].typed, dir_tab[i].xb, dir_tab[i].xs);
		while (items_in < 180) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			make_string();
			foreach (burst[i]) send_item(burst[i][7:0], burst[i][8], 1'b0, 8'h00, ST_DATA);
		end
		s_tvalid <= 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("[json_string_unescape] OK");
		else $display("[json_string_unescape] ERROR");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("[json_string_unescape] ERROR");
		$finish;
	end

endmodule
